FILE: hw/rtl/wfs_pkg.sv
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types, constants and helpers of the wire-format field skipper.
// ----------------------------------------------------------------------------
package wfs_pkg;

   localparam int WFS_MAX_DEPTH = 16;
   localparam logic [4:0] WFS_DEPTH_LIMIT_RESET = 5'd16;

   localparam int FIELD_NUM_W = 29;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_TRUNCATED = 3'd1;
   localparam logic [2:0] ST_OVERLONG = 3'd2;
   localparam logic [2:0] ST_BAD_WIRE = 3'd3;
   localparam logic [2:0] ST_DEPTH = 3'd4;
   localparam logic [2:0] ST_MISMATCH = 3'd5;

   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LENGTH = 3'd2;
   localparam logic [2:0] WT_START_GROUP = 3'd3;
   localparam logic [2:0] WT_END_GROUP = 3'd4;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   typedef struct packed {
      logic                   valid;
      logic [FIELD_NUM_W-1:0] field_num;
   } push_type;

   // merge one varint byte into the low 32 bits of an accumulator
   function automatic logic [31:0] add_varint(input logic [31:0] acc,
                                              input logic [3:0] idx,
                                              input logic [7:0] b);
      logic [31:0] r;
      begin
         case (idx)
            4'd0: r = acc | {25'b0, b[6:0]};
            4'd1: r = acc | {18'b0, b[6:0], 7'b0};
            4'd2: r = acc | {11'b0, b[6:0], 14'b0};
            4'd3: r = acc | {4'b0, b[6:0], 21'b0};
            4'd4: r = acc | {b[3:0], 28'b0};
            default: r = acc;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: hw/rtl/wfs_stack.sv
// ----------------------------------------------------------------------------
// wfs_stack
// Group stack in a synchronous memory. Presents the top entry every cycle:
// the entry below the next depth is read at each edge, a push is forwarded.
// ----------------------------------------------------------------------------
module wfs_stack #(
   parameter int MAX_DEPTH = wfs_pkg::WFS_MAX_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(MAX_DEPTH+1)-1:0]      depth_cur,
   input  logic [$clog2(MAX_DEPTH+1)-1:0]      depth_next,
   input  wfs_pkg::push_type                   push,
   output logic [wfs_pkg::FIELD_NUM_W-1:0]     top
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [wfs_pkg::FIELD_NUM_W-1:0] stack_mem [MAX_DEPTH];
   logic [wfs_pkg::FIELD_NUM_W-1:0] rd_data_ff;
   logic [wfs_pkg::FIELD_NUM_W-1:0] fwd_data_ff;
   logic                            fwd_ff;
   logic [DW-1:0]                   next_m1;
   logic [AW-1:0]                   rd_addr;
   logic [AW-1:0]                   wr_addr;

   assign next_m1 = depth_next - DW'(1);
   assign rd_addr = (depth_next == '0) ? '0 : next_m1[AW-1:0];
   assign wr_addr = depth_cur[AW-1:0];

   always_ff @(posedge clock) begin
      if (push.valid) begin
         stack_mem[wr_addr] <= push.field_num;
      end
      rd_data_ff <= stack_mem[rd_addr];
      fwd_data_ff <= push.field_num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= push.valid;
      end
   end

   assign top = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

FILE: hw/rtl/wire_format_field_skipper_core.sv
// ----------------------------------------------------------------------------
// wire_format_field_skipper_core
// Walks a tagged binary message one byte per word and reports one status.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while req_stall is low, bytes and end markers
// alike. Every byte is decoded in the cycle it is accepted; the only stored
// lookup is the group stack, a one-port-read memory whose top entry is fetched
// ahead and forwarded on a push, so nesting never stalls the input. A status
// word leaves through an output register backed by one skid entry; req_stall
// rises only when both hold undelivered status words. After a status the
// block drops bytes until the end marker, which starts a new message. Nesting
// is limited to MAX_DEPTH and to csr_wr_data as last written (16 on reset).
module wire_format_field_skipper_core #(
   parameter int MAX_DEPTH = wfs_pkg::WFS_MAX_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_is_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_field_count,
   output logic [31:0] rsp_byte_count,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int CW = (DW > 5) ? DW : 5;

   typedef enum logic [4:0] {
      PH_TAG    = 5'b00001,
      PH_VARINT = 5'b00010,
      PH_FIXED  = 5'b00100,
      PH_LENGTH = 5'b01000,
      PH_BODY   = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] tag_ff, tag_in;
   logic [3:0]  vidx_ff, vidx_in;
   logic [31:0] rem_ff, rem_in;
   logic [3:0]  fixed_ff, fixed_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [15:0] fields_ff, fields_in;
   logic [31:0] bytes_ff, bytes_in;
   logic        draining_ff, draining_in;
   logic [4:0]  depth_limit_ff;

   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic [15:0] out_fields_ff, out_fields_in;
   logic [31:0] out_bytes_ff, out_bytes_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [2:0]  skid_status_ff, skid_status_in;
   logic [15:0] skid_fields_ff, skid_fields_in;
   logic [31:0] skid_bytes_ff, skid_bytes_in;

   logic        accept;
   logic        res_valid;
   logic [2:0]  res_status;
   logic [31:0] res_bytes;
   logic        pop;
   logic [CW-1:0] limit;
   logic [wfs_pkg::FIELD_NUM_W-1:0] stack_top;
   logic [wfs_pkg::FIELD_NUM_W-1:0] field_num;
   wfs_pkg::push_type push;

   wfs_stack #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .depth_cur  (depth_ff),
      .depth_next (depth_in),
      .push       (push),
      .top        (stack_top)
   );

   assign req_stall = skid_valid_ff;
   assign accept = req_valid & ~req_stall;
   assign pop = out_valid_ff & ~rsp_stall;
   assign limit = (CW'(depth_limit_ff) < CW'(MAX_DEPTH)) ? CW'(depth_limit_ff)
                                                           : CW'(MAX_DEPTH);

   always_comb begin
      phase_in = phase_ff;
      tag_in = tag_ff;
      vidx_in = vidx_ff;
      rem_in = rem_ff;
      fixed_in = fixed_ff;
      depth_in = depth_ff;
      fields_in = fields_ff;
      bytes_in = bytes_ff;
      draining_in = draining_ff;
      res_valid = 1'b0;
      res_status = wfs_pkg::ST_OK;
      res_bytes = bytes_ff;
      push.valid = 1'b0;
      push.field_num = '0;
      field_num = '0;

      if (accept) begin
         if (req_is_end) begin
            if (!draining_ff) begin
               res_valid = 1'b1;
               res_status = (phase_ff == PH_TAG && vidx_ff == '0 && depth_ff == '0)
                            ? wfs_pkg::ST_OK : wfs_pkg::ST_TRUNCATED;
            end
            phase_in = PH_TAG;
            tag_in = '0;
            vidx_in = '0;
            rem_in = '0;
            fixed_in = '0;
            depth_in = '0;
            fields_in = '0;
            bytes_in = '0;
            draining_in = 1'b0;
         end else if (!draining_ff) begin
            if (bytes_ff != '1) begin
               bytes_in = bytes_ff + 32'd1;
            end
            res_bytes = bytes_in;
            case (phase_ff)
               PH_TAG: begin
                  tag_in = wfs_pkg::add_varint(tag_ff, vidx_ff, req_in_byte);
                  vidx_in = vidx_ff + 4'd1;
                  if (req_in_byte[7]) begin
                     if (vidx_in >= 4'd5) begin
                        res_valid = 1'b1;
                        res_status = wfs_pkg::ST_OVERLONG;
                     end
                  end else begin
                     field_num = tag_in[31:3];
                     vidx_in = '0;
                     if (tag_in == '0) begin
                        res_valid = 1'b1;
                        res_status = (depth_ff == '0) ? wfs_pkg::ST_OK
                                                      : wfs_pkg::ST_MISMATCH;
                     end else if (tag_in[2:0] == wfs_pkg::WT_END_GROUP) begin
                        if (depth_ff == '0) begin
                           res_valid = 1'b1;
                           res_status = wfs_pkg::ST_OK;
                        end else if (field_num != stack_top) begin
                           res_valid = 1'b1;
                           res_status = wfs_pkg::ST_MISMATCH;
                        end else begin
                           depth_in = depth_ff - DW'(1);
                           phase_in = PH_TAG;
                           if (depth_in == '0 && fields_ff != '1) begin
                              fields_in = fields_ff + 16'd1;
                           end
                        end
                     end else if (field_num == '0) begin
                        res_valid = 1'b1;
                        res_status = wfs_pkg::ST_BAD_WIRE;
                     end else begin
                        case (tag_in[2:0])
                           wfs_pkg::WT_VARINT: phase_in = PH_VARINT;
                           wfs_pkg::WT_FIXED64: begin
                              phase_in = PH_FIXED;
                              fixed_in = 4'd8;
                           end
                           wfs_pkg::WT_FIXED32: begin
                              phase_in = PH_FIXED;
                              fixed_in = 4'd4;
                           end
                           wfs_pkg::WT_LENGTH: begin
                              phase_in = PH_LENGTH;
                              rem_in = '0;
                           end
                           wfs_pkg::WT_START_GROUP: begin
                              if (CW'(depth_ff) >= limit) begin
                                 res_valid = 1'b1;
                                 res_status = wfs_pkg::ST_DEPTH;
                              end else begin
                                 push.valid = 1'b1;
                                 push.field_num = field_num;
                                 depth_in = depth_ff + DW'(1);
                                 phase_in = PH_TAG;
                              end
                           end
                           default: begin
                              res_valid = 1'b1;
                              res_status = wfs_pkg::ST_BAD_WIRE;
                           end
                        endcase
                     end
                     tag_in = '0;
                  end
               end
               PH_VARINT: begin
                  vidx_in = vidx_ff + 4'd1;
                  if (req_in_byte[7]) begin
                     if (vidx_in >= 4'd10) begin
                        res_valid = 1'b1;
                        res_status = wfs_pkg::ST_OVERLONG;
                     end
                  end else begin
                     vidx_in = '0;
                     phase_in = PH_TAG;
                     if (depth_ff == '0 && fields_ff != '1) begin
                        fields_in = fields_ff + 16'd1;
                     end
                  end
               end
               PH_FIXED: begin
                  if (fixed_ff != '0) begin
                     fixed_in = fixed_ff - 4'd1;
                  end
                  if (fixed_in == '0) begin
                     phase_in = PH_TAG;
                     if (depth_ff == '0 && fields_ff != '1) begin
                        fields_in = fields_ff + 16'd1;
                     end
                  end
               end
               PH_LENGTH: begin
                  rem_in = wfs_pkg::add_varint(rem_ff, vidx_ff, req_in_byte);
                  vidx_in = vidx_ff + 4'd1;
                  if (req_in_byte[7]) begin
                     if (vidx_in >= 4'd10) begin
                        res_valid = 1'b1;
                        res_status = wfs_pkg::ST_OVERLONG;
                     end
                  end else begin
                     vidx_in = '0;
                     if (rem_in[31]) begin
                        res_valid = 1'b1;
                        res_status = wfs_pkg::ST_TRUNCATED;
                     end else if (rem_in == '0) begin
                        phase_in = PH_TAG;
                        if (depth_ff == '0 && fields_ff != '1) begin
                           fields_in = fields_ff + 16'd1;
                        end
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end
               PH_BODY: begin
                  if (rem_ff != '0) begin
                     rem_in = rem_ff - 32'd1;
                  end
                  if (rem_in == '0) begin
                     phase_in = PH_TAG;
                     if (depth_ff == '0 && fields_ff != '1) begin
                        fields_in = fields_ff + 16'd1;
                     end
                  end
               end
               default: phase_in = PH_TAG;
            endcase
            if (res_valid) begin
               draining_in = 1'b1;
            end
         end
      end
   end

   // output register with one skid entry
   always_comb begin
      out_valid_in = out_valid_ff;
      out_status_in = out_status_ff;
      out_fields_in = out_fields_ff;
      out_bytes_in = out_bytes_ff;
      skid_valid_in = skid_valid_ff;
      skid_status_in = skid_status_ff;
      skid_fields_in = skid_fields_ff;
      skid_bytes_in = skid_bytes_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_status_in = skid_status_ff;
            out_fields_in = skid_fields_ff;
            out_bytes_in = skid_bytes_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_status_in = res_status;
            out_fields_in = fields_ff;
            out_bytes_in = res_bytes;
         end else begin
            skid_valid_in = 1'b1;
            skid_status_in = res_status;
            skid_fields_in = fields_ff;
            skid_bytes_in = res_bytes;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         tag_ff <= '0;
         vidx_ff <= '0;
         rem_ff <= '0;
         fixed_ff <= '0;
         depth_ff <= '0;
         fields_ff <= '0;
         bytes_ff <= '0;
         draining_ff <= 1'b0;
         depth_limit_ff <= wfs_pkg::WFS_DEPTH_LIMIT_RESET;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         tag_ff <= tag_in;
         vidx_ff <= vidx_in;
         rem_ff <= rem_in;
         fixed_ff <= fixed_in;
         depth_ff <= depth_in;
         fields_ff <= fields_in;
         bytes_ff <= bytes_in;
         draining_ff <= draining_in;
         if (csr_wr_en) begin
            depth_limit_ff <= csr_wr_data;
         end
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_fields_ff <= out_fields_in;
      out_bytes_ff <= out_bytes_in;
      skid_status_ff <= skid_status_in;
      skid_fields_ff <= skid_fields_in;
      skid_bytes_ff <= skid_bytes_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_field_count = out_fields_ff;
   assign rsp_byte_count = out_bytes_ff;

endmodule
